FILE: hdl/pli_pkg.sv
`default_nettype none

package pli_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_KNOTS = 64;
  localparam int DEF_FRAC_BITS = 16;

  // Fixed field widths
  localparam int VAL_W = 32;
  localparam int RES_W = 48;
  // Antiderivative accumulator; largest term is |dv|*dx^2/|dp| < 2^96
  localparam int ACC_W = 104;
  // Numerator width of the serial divider
  localparam int NUM_W = 96;

  // Operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_INTEG = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_USE_FLOOR      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EVAL_FLOOR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_FLOOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_COUNT     = 3'd5;

  // Reset values
  localparam logic signed [VAL_W-1:0] RST_WINDOW_LOW  = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] RST_WINDOW_HIGH = -32'sh0001_0000;
  localparam logic [6:0] RST_KNOT_COUNT = 7'd1;

  typedef struct packed {
    logic [1:0]              operation;
    logic [5:0]              knot_index;
    logic signed [VAL_W-1:0] knot_position;
    logic signed [VAL_W-1:0] knot_value;
    logic signed [VAL_W-1:0] query_low;
    logic signed [VAL_W-1:0] query_high;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic                    floor_applied;
    logic                    outside_window;
    logic                    saturated;
  } out_word_t;

endpackage

`default_nettype wire

FILE: hdl/pli_ram.sv
`default_nettype none

module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/piecewise_linear_interpolator.sv
`default_nettype none

// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_stall    pli_pkg::in_word_t  (load, evaluate, integrate)
// out      out  out_valid / out_stall  pli_pkg::out_word_t (one word per evaluate/integrate)
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready is always high)
//
// A load is written to the knot table when it is accepted. An integrate, or an
// evaluate inside the window, scans the table one entry per ST_RD/ST_DAT/ST_ACC pass,
// and each bound runs a restoring divide of the 96-bit numerator by the knot spacing,
// skipped when the spacing is zero. Reset clears the FSM, out_valid and the config
// registers; the knot table and out_data are not cleared. One word is worked on at a
// time; in_stall is high while busy. A finished result sits in the output register,
// so loads and the next query are taken while out_stall holds it.

module piecewise_linear_interpolator #(
  parameter int MAX_KNOTS = pli_pkg::DEF_MAX_KNOTS,
  parameter int FRAC_BITS = pli_pkg::DEF_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire pli_pkg::in_word_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output pli_pkg::out_word_t                    out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pli_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pli_pkg::VAL_W-1:0]        cfg_data
);

  localparam int AW    = $clog2(MAX_KNOTS);
  localparam int CW    = $clog2(MAX_KNOTS + 1);
  localparam int VW    = pli_pkg::VAL_W;
  localparam int AC    = pli_pkg::ACC_W;
  localparam int NW    = pli_pkg::NUM_W;
  localparam int RW    = pli_pkg::RES_W;
  localparam int DCW   = $clog2(NW);

  // FSM codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;   // issue table read
  localparam logic [3:0] ST_DAT   = 4'd2;   // segment test, trapezoid multiply
  localparam logic [3:0] ST_ACC   = 4'd3;   // prefix sum
  localparam logic [3:0] ST_SETUP = 4'd4;   // per-bound deltas
  localparam logic [3:0] ST_M1    = 4'd5;   // 2*v*dx
  localparam logic [3:0] ST_M2    = 4'd6;   // |dv|*|dx|
  localparam logic [3:0] ST_M3    = 4'd7;   // low partial of *|dx|
  localparam logic [3:0] ST_M4    = 4'd8;   // high partial of *|dx|
  localparam logic [3:0] ST_M5    = 4'd9;   // combine partials
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_RND   = 4'd11;
  localparam logic [3:0] ST_BEND  = 4'd12;  // bound finished
  localparam logic [3:0] ST_FIN   = 4'd13;  // difference and rounding
  localparam logic [3:0] ST_FIN2  = 4'd14;
  localparam logic [3:0] ST_FIN3  = 4'd15;

  // ---------------------------------------------------------------- config
  logic                 use_floor;
  logic signed [VW-1:0] eval_floor;
  logic signed [VW-1:0] integral_floor;
  logic signed [VW-1:0] window_low;
  logic signed [VW-1:0] window_high;
  logic [6:0]           knot_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_floor      <= 1'b1;
      eval_floor     <= '0;
      integral_floor <= '0;
      window_low     <= pli_pkg::RST_WINDOW_LOW;
      window_high    <= pli_pkg::RST_WINDOW_HIGH;
      knot_count     <= pli_pkg::RST_KNOT_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pli_pkg::REG_USE_FLOOR:      use_floor      <= cfg_data[0];
        pli_pkg::REG_EVAL_FLOOR:     eval_floor     <= $signed(cfg_data);
        pli_pkg::REG_INTEGRAL_FLOOR: integral_floor <= $signed(cfg_data);
        pli_pkg::REG_WINDOW_LOW:     window_low     <= $signed(cfg_data);
        pli_pkg::REG_WINDOW_HIGH:    window_high    <= $signed(cfg_data);
        pli_pkg::REG_KNOT_COUNT:     knot_count     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic window_on;
  assign window_on = (window_low <= window_high);

  // knots in use, clamped to 1..MAX_KNOTS; n_last is the last index scanned
  logic [CW-1:0] n_use;
  logic [CW-1:0] n_last;
  always_comb begin
    if (knot_count == 7'd0) begin
      n_use = CW'(1);
    end else if (32'(knot_count) > MAX_KNOTS) begin
      n_use = CW'(MAX_KNOTS);
    end else begin
      n_use = CW'(knot_count);
    end
    n_last = n_use - CW'(1);
  end

  // ---------------------------------------------------------------- state
  logic [3:0]           state;
  logic [3:0]           state_next;
  logic                 is_int;
  logic                 outside;
  logic [CW-1:0]        k;
  logic signed [VW-1:0] x_b [2];        // [0] low bound, [1] high bound
  logic [1:0]           found;
  logic signed [VW-1:0] prev_p, prev_v;
  logic signed [VW-1:0] seg0_p, seg0_v, seg0_p1, seg0_v1;
  logic signed [VW-1:0] seg_pb [2];
  logic signed [VW-1:0] seg_vb [2];
  logic signed [VW-1:0] seg_pb1 [2];
  logic signed [VW-1:0] seg_vb1 [2];
  logic signed [AC-1:0] pre_b [2];
  logic signed [AC-1:0] prefix;
  logic                 bsel;
  logic signed [VW:0]   dp_r, dv_r, dx_r;
  logic signed [VW-1:0] vb_r;
  logic signed [AC-1:0] acc;
  logic signed [AC-1:0] a_hi;
  logic                 d_neg;
  logic [VW-1:0]        mhi;
  logic [NW-1:0]        num;
  logic [VW-1:0]        rem;
  logic [DCW-1:0]       dcnt;
  logic signed [AC-1:0] res_wide;

  // ---------------------------------------------------------------- input
  logic in_acc;
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  logic signed [VW-1:0] lo_c, hi_c;
  logic                 eval_out;
  always_comb begin
    lo_c = in_data.query_low;
    hi_c = in_data.query_high;
    if (window_on) begin
      if (lo_c < window_low)  lo_c = window_low;
      if (lo_c > window_high) lo_c = window_high;
      if (hi_c < window_low)  hi_c = window_low;
      if (hi_c > window_high) hi_c = window_high;
    end
    eval_out = window_on && ((in_data.query_low < window_low) ||
                             (in_data.query_low > window_high));
  end

  // ---------------------------------------------------------------- knot table
  logic                  ram_we;
  logic                  ram_re;
  logic [2*VW-1:0]       ram_q;

  assign ram_we = in_acc && (in_data.operation == pli_pkg::OP_LOAD) &&
                  (32'(in_data.knot_index) < MAX_KNOTS);
  assign ram_re = (state == ST_RD);

  pli_ram #(
    .WIDTH (2 * VW),
    .DEPTH (MAX_KNOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (AW'(in_data.knot_index)),
    .wr_data ({in_data.knot_position, in_data.knot_value}),
    .rd_en   (ram_re),
    .rd_addr (k[AW-1:0]),
    .rd_data (ram_q)
  );

  logic signed [VW-1:0] cur_p, cur_v;
  logic [1:0]           hit;
  assign cur_p = $signed(ram_q[2*VW-1:VW]);
  assign cur_v = $signed(ram_q[VW-1:0]);

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      hit[b] = (k != '0) && !found[b] && (x_b[b] >= prev_p) && (x_b[b] < cur_p);
    end
  end

  // ---------------------------------------------------------------- magnitudes
  logic signed [VW:0] dp_abs, dv_abs, dx_abs;
  logic [VW-1:0]      dp_mag, dv_mag, dx_mag;
  logic               dp_zero;
  always_comb begin
    dp_abs  = dp_r[VW] ? -dp_r : dp_r;
    dv_abs  = dv_r[VW] ? -dv_r : dv_r;
    dx_abs  = dx_r[VW] ? -dx_r : dx_r;
    dp_mag  = dp_abs[VW-1:0];
    dv_mag  = dv_abs[VW-1:0];
    dx_mag  = dx_abs[VW-1:0];
    dp_zero = (dp_r == '0);
  end

  // ---------------------------------------------------------------- multiplier
  // one shared 34x34 signed multiplier, product registered
  logic signed [VW+1:0]     mul_a, mul_b;
  logic signed [2*VW+3:0]   prod;
  always_comb begin
    case (state)
      ST_DAT: begin
        // knot order is not enforced, so both operands are sign-extended
        mul_a = (VW+2)'(cur_p) - (VW+2)'(prev_p);
        mul_b = (VW+2)'(prev_v) + (VW+2)'(cur_v);
      end
      ST_M1: begin
        mul_a = (VW+2)'($signed({vb_r, 1'b0}));
        mul_b = (VW+2)'(dx_r);
      end
      ST_M2: begin
        mul_a = $signed({2'b00, dv_mag});
        mul_b = $signed({2'b00, dx_mag});
      end
      ST_M3: begin
        mul_a = $signed({2'b00, prod[VW-1:0]});
        mul_b = $signed({2'b00, dx_mag});
      end
      ST_M4: begin
        mul_a = $signed({2'b00, mhi});
        mul_b = $signed({2'b00, dx_mag});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------- divider step
  logic [VW:0]          trial;
  logic                 qbit;
  logic [VW:0]          trial_sub;
  always_comb begin
    trial     = {rem, num[NW-1]};
    qbit      = (trial >= {1'b0, dp_mag});
    trial_sub = trial - {1'b0, dp_mag};
  end

  // rounded quotient, signed
  logic [NW:0]          q_round;
  logic signed [AC-1:0] q_s;
  logic                 q_neg;
  always_comb begin
    q_round = {1'b0, num} + (NW+1)'({rem, 1'b0} >= {1'b0, dp_mag});
    q_s     = $signed(AC'(q_round));
    q_neg   = is_int ? (dv_r[VW] ^ dp_r[VW]) : (dv_r[VW] ^ dx_r[VW] ^ dp_r[VW]);
  end

  // ---------------------------------------------------------------- saturate, floor
  logic signed [RW-1:0] sat_val;
  logic                 sat_clip;
  logic signed [RW-1:0] floor_val;
  pli_pkg::out_word_t   res_word;
  always_comb begin
    if ((res_wide[AC-1:RW-1] == '0) || (res_wide[AC-1:RW-1] == '1)) begin
      sat_val  = res_wide[RW-1:0];
      sat_clip = 1'b0;
    end else if (res_wide[AC-1]) begin
      sat_val  = {1'b1, {(RW-1){1'b0}}};
      sat_clip = 1'b1;
    end else begin
      sat_val  = {1'b0, {(RW-1){1'b1}}};
      sat_clip = 1'b1;
    end
    floor_val = is_int ? RW'(integral_floor) : RW'(eval_floor);
    res_word.outside_window = outside;
    if (use_floor && (sat_val < floor_val)) begin
      res_word.result_value  = floor_val;
      res_word.floor_applied = 1'b1;
      res_word.saturated     = 1'b0;
    end else begin
      res_word.result_value  = sat_val;
      res_word.floor_applied = 1'b0;
      res_word.saturated     = sat_clip;
    end
  end

  // ---------------------------------------------------------------- FSM
  logic out_free;
  logic hold_ready;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.operation)
            pli_pkg::OP_EVAL:  state_next = eval_out ? ST_FIN3 : ST_RD;
            pli_pkg::OP_INTEG: state_next = ST_RD;
            default:           state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD:    state_next = ST_DAT;
      ST_DAT:   state_next = ST_ACC;
      ST_ACC:   state_next = (k == n_last) ? ST_SETUP : ST_RD;
      ST_SETUP: state_next = ST_M1;
      ST_M1:    state_next = ST_M2;
      ST_M2:    state_next = ST_M3;
      ST_M3: begin
        if (dp_zero) begin
          state_next = ST_BEND;
        end else begin
          state_next = is_int ? ST_M4 : ST_DIV;
        end
      end
      ST_M4:    state_next = ST_M5;
      ST_M5:    state_next = ST_DIV;
      ST_DIV:   state_next = (dcnt == DCW'(NW - 1)) ? ST_RND : ST_DIV;
      ST_RND:   state_next = ST_BEND;
      ST_BEND: begin
        if (is_int && bsel) begin
          state_next = ST_SETUP;
        end else begin
          state_next = is_int ? ST_FIN : ST_FIN3;
        end
      end
      ST_FIN:   state_next = ST_FIN2;
      ST_FIN2:  state_next = ST_FIN3;
      // ST_FIN3 doubles as the result stage: settle res_wide, then wait for
      // the output register
      ST_FIN3:  state_next = (hold_ready && out_free) ? ST_IDLE : ST_FIN3;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result staging: hold_ready marks res_wide settled, res_word then feeds out_data
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ready <= 1'b0;
    end else if (state == ST_FIN3 && !hold_ready) begin
      hold_ready <= 1'b1;
    end else if (state == ST_FIN3 && out_free) begin
      hold_ready <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN3 && hold_ready && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN3 && hold_ready && out_free) begin
      out_data <= res_word;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          is_int  <= (in_data.operation == pli_pkg::OP_INTEG);
          outside <= (in_data.operation == pli_pkg::OP_EVAL) && eval_out;
          k       <= '0;
          found   <= '0;
          prefix  <= '0;
          bsel    <= 1'b1;
          res_wide <= '0;
          if (in_data.operation == pli_pkg::OP_INTEG) begin
            x_b[0] <= lo_c;
            x_b[1] <= hi_c;
          end else begin
            x_b[0] <= in_data.query_low;
            x_b[1] <= in_data.query_low;
          end
        end
      end
      ST_DAT: begin
        for (int b = 0; b < 2; b++) begin
          if (hit[b]) begin
            found[b]   <= 1'b1;
            seg_pb[b]  <= prev_p;
            seg_vb[b]  <= prev_v;
            seg_pb1[b] <= cur_p;
            seg_vb1[b] <= cur_v;
            pre_b[b]   <= prefix;
          end else if (k == n_last && !found[b]) begin
            if (k == '0) begin
              // single knot: constant
              seg_pb[b]  <= cur_p;
              seg_vb[b]  <= cur_v;
              seg_pb1[b] <= cur_p;
              seg_vb1[b] <= cur_v;
              pre_b[b]   <= '0;
            end else if ((x_b[b] >= cur_p) || (k == CW'(1))) begin
              // past the last knot: extend the last segment
              seg_pb[b]  <= prev_p;
              seg_vb[b]  <= prev_v;
              seg_pb1[b] <= cur_p;
              seg_vb1[b] <= cur_v;
              pre_b[b]   <= prefix;
            end else begin
              // before the first knot: extend the first segment
              seg_pb[b]  <= seg0_p;
              seg_vb[b]  <= seg0_v;
              seg_pb1[b] <= seg0_p1;
              seg_vb1[b] <= seg0_v1;
              pre_b[b]   <= '0;
            end
          end
        end
        if (k == CW'(1)) begin
          seg0_p  <= prev_p;
          seg0_v  <= prev_v;
          seg0_p1 <= cur_p;
          seg0_v1 <= cur_v;
        end
        prev_p <= cur_p;
        prev_v <= cur_v;
      end
      ST_ACC: begin
        if (k != '0) begin
          prefix <= prefix + AC'(prod);
        end
        if (k != n_last) begin
          k <= k + CW'(1);
        end
      end
      ST_SETUP: begin
        dp_r <= {seg_pb1[bsel][VW-1], seg_pb1[bsel]} - {seg_pb[bsel][VW-1], seg_pb[bsel]};
        dv_r <= {seg_vb1[bsel][VW-1], seg_vb1[bsel]} - {seg_vb[bsel][VW-1], seg_vb[bsel]};
        dx_r <= {x_b[bsel][VW-1], x_b[bsel]} - {seg_pb[bsel][VW-1], seg_pb[bsel]};
        vb_r <= seg_vb[bsel];
        acc  <= is_int ? pre_b[bsel] : AC'(seg_vb[bsel]);
      end
      ST_M2: begin
        if (is_int) begin
          acc <= acc + AC'(prod);   // 2*v*dx
        end
      end
      ST_M3: begin
        mhi  <= prod[2*VW-1:VW];
        num  <= NW'(prod[2*VW-1:0]);
        rem  <= '0;
        dcnt <= '0;
      end
      ST_M4: begin
        num <= NW'(prod[2*VW-1:0]);
      end
      ST_M5: begin
        num <= num + {prod[NW-VW-1:0], {VW{1'b0}}};
      end
      ST_DIV: begin
        rem  <= qbit ? trial_sub[VW-1:0] : trial[VW-1:0];
        num  <= {num[NW-2:0], qbit};
        dcnt <= dcnt + DCW'(1);
      end
      ST_RND: begin
        acc <= acc + (q_neg ? -q_s : q_s);
      end
      ST_BEND: begin
        if (is_int && bsel) begin
          a_hi <= acc;
          bsel <= 1'b0;
        end else if (!is_int) begin
          res_wide <= acc;
        end
      end
      ST_FIN: begin
        acc <= a_hi - acc;
      end
      ST_FIN2: begin
        // magnitude plus half an output LSB, ties away from zero
        d_neg <= acc[AC-1];
        acc   <= (acc[AC-1] ? -acc : acc) + (AC'(1) <<< FRAC_BITS);
      end
      ST_FIN3: begin
        if (is_int && !hold_ready) begin
          res_wide <= d_neg ? -(acc >>> (FRAC_BITS + 1)) : (acc >>> (FRAC_BITS + 1));
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
